// File: rtl/fcd_pkg.sv
// ----------------------------------------------------------------------------
// Framed command deframer package
// Shared constants, codes and the command and status structs that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package fcd_pkg;

  // Default window depth in bytes.
  localparam int BufDepthDefault = 128;

  // Frame layout: two STX bytes, command, length, data, two ETX bytes.
  localparam int       FrameOverhead = 6;
  localparam int       MaxWords      = 31;
  localparam logic [7:0] StxByte     = 8'hFF;
  localparam logic [7:0] EtxByte     = 8'hFE;
  localparam logic [7:0] CmdLow      = 8'h01;
  localparam logic [7:0] CmdHigh     = 8'h08;

  // Result status codes.
  typedef enum logic [2:0] {
    StFew  = 3'd0,
    StWait = 3'd1,
    StStx  = 3'd2,
    StCmd  = 3'd3,
    StEtx  = 3'd4,
    StLong = 3'd5,
    StWord = 3'd6
  } fcd_status_e;

  // Controller states.
  typedef enum logic [3:0] {
    SIdle,
    SCheck,
    SHdr0,
    SHdr1,
    SCmd,
    SLen,
    SEtx0,
    SEtx1,
    SData
  } fcd_state_e;

  // Window read offset selection.
  typedef enum logic [2:0] {
    RselHdr0,
    RselHdr1,
    RselCmd,
    RselLen,
    RselEtx0,
    RselEtx1,
    RselData
  } fcd_rsel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        push;
    fcd_rsel_e   rsel;
    logic        cap_hdr0;
    logic        cap_hdr1;
    logic        cap_cmd;
    logic        cap_len;
    logic        cap_etx0;
    logic        set_pend;
    logic        clr_pend;
    logic        drop_one;
    logic        drop_frame;
    logic        pos_clr;
    logic        pos_inc;
    logic        emit;
    fcd_status_e emit_status;
    logic        emit_word;
    logic        emit_last;
  } fcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic few;
    logic stx_bad;
    logic cmd_bad;
    logic len_long;
    logic len_wait;
    logic etx_bad;
    logic len_zero;
    logic word_end;
    logic frame_end;
  } fcd_stat_t;

endpackage

// File: rtl/fcd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module fcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fcd_ctrl.sv
// ----------------------------------------------------------------------------
// Deframer controller
// State machine that sequences the window reads of one parse attempt and
// tells the datapath what to capture, drop and emit.
// ----------------------------------------------------------------------------
module fcd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               mode_i,
  input  fcd_pkg::fcd_stat_t stat_i,
  output fcd_pkg::fcd_cmd_t  cmd_o,
  output logic               busy_o
);
  import fcd_pkg::*;

  fcd_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (start_i && mode_i) state_d = SCheck;
      end
      SCheck: begin
        state_d = stat_i.few ? SIdle : SHdr0;
      end
      SHdr0: state_d = SHdr1;
      SHdr1: state_d = SCmd;
      SCmd: begin
        state_d = (stat_i.stx_bad || stat_i.cmd_bad) ? SIdle : SLen;
      end
      SLen: begin
        state_d = (stat_i.len_long || stat_i.len_wait) ? SIdle : SEtx0;
      end
      SEtx0: state_d = SEtx1;
      SEtx1: begin
        state_d = (stat_i.etx_bad || stat_i.len_zero) ? SIdle : SData;
      end
      SData: begin
        if (stat_i.frame_end) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o             = '0;
    cmd_o.rsel        = RselHdr0;
    cmd_o.emit_status = StFew;
    unique case (state_q)
      SIdle: begin
        cmd_o.push = start_i && !mode_i;
      end
      SCheck: begin
        // Not enough bytes for the frame known so far: report and stop.
        if (stat_i.few) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = StFew;
          cmd_o.emit_last   = 1'b1;
        end
        cmd_o.rsel = RselHdr0;
      end
      SHdr0: begin
        cmd_o.cap_hdr0 = 1'b1;
        cmd_o.rsel     = RselHdr1;
      end
      SHdr1: begin
        cmd_o.cap_hdr1 = 1'b1;
        cmd_o.rsel     = RselCmd;
      end
      SCmd: begin
        // Header bytes are held; the command byte is on the read data.
        cmd_o.cap_cmd  = 1'b1;
        cmd_o.rsel     = RselLen;
        if (stat_i.stx_bad || stat_i.cmd_bad) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = stat_i.stx_bad ? StStx : StCmd;
          cmd_o.emit_last   = 1'b1;
          cmd_o.drop_one    = 1'b1;
          cmd_o.clr_pend    = 1'b1;
        end
      end
      SLen: begin
        cmd_o.cap_len = 1'b1;
        cmd_o.rsel    = RselEtx0;
        if (stat_i.len_long) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = StLong;
          cmd_o.emit_last   = 1'b1;
          cmd_o.drop_one    = 1'b1;
          cmd_o.clr_pend    = 1'b1;
        end else if (stat_i.len_wait) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = StWait;
          cmd_o.emit_last   = 1'b1;
          cmd_o.set_pend    = 1'b1;
        end
      end
      SEtx0: begin
        // The first ETX byte is captured while the second one is being read.
        cmd_o.cap_etx0 = 1'b1;
        cmd_o.rsel     = RselEtx1;
      end
      SEtx1: begin
        cmd_o.rsel     = RselData;
        cmd_o.pos_clr  = 1'b1;
        if (stat_i.etx_bad) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = StEtx;
          cmd_o.emit_last   = 1'b1;
          cmd_o.drop_one    = 1'b1;
          cmd_o.clr_pend    = 1'b1;
        end else if (stat_i.len_zero) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = StWord;
          cmd_o.emit_last   = 1'b1;
          cmd_o.drop_frame  = 1'b1;
          cmd_o.clr_pend    = 1'b1;
        end
      end
      SData: begin
        // One data byte per cycle; a full word goes out every fourth byte.
        cmd_o.rsel    = RselData;
        cmd_o.pos_inc = 1'b1;
        if (stat_i.word_end) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = StWord;
          cmd_o.emit_word   = 1'b1;
          cmd_o.emit_last   = stat_i.frame_end;
        end
        if (stat_i.frame_end) begin
          cmd_o.drop_frame = 1'b1;
          cmd_o.clr_pend   = 1'b1;
        end
      end
      default: begin
        cmd_o.rsel = RselHdr0;
      end
    endcase
  end

  assign busy_o = (state_q != SIdle);

endmodule

// File: rtl/fcd_dp.sv
// ----------------------------------------------------------------------------
// Deframer datapath
// Ring window, pointers and counts, header and word registers, and the
// registered result outputs.
// ----------------------------------------------------------------------------
module fcd_dp #(
  parameter int BUF_DEPTH = fcd_pkg::BufDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         byte_in_i,
  input  fcd_pkg::fcd_cmd_t  cmd_i,
  output fcd_pkg::fcd_stat_t stat_o,
  output logic               strobe_o,
  output logic [2:0]         status_o,
  output logic [7:0]         command_o,
  output logic [7:0]         frame_length_o,
  output logic [4:0]         word_index_o,
  output logic [31:0]        data_word_o,
  output logic               word_valid_o,
  output logic               last_o
);
  import fcd_pkg::*;

  localparam int PTR_W = $clog2(BUF_DEPTH);
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int SUM_W = ((PTR_W > 9) ? PTR_W : 9) + 1;
  localparam int CMP_W = ((CNT_W > 9) ? CNT_W : 9) + 1;
  localparam int LimitRaw    = BUF_DEPTH - FrameOverhead;
  localparam int LenLimitInt = (LimitRaw > MaxWords * 4) ? MaxWords * 4 : LimitRaw;
  localparam logic [7:0] LenLimit = 8'(LenLimitInt);

  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       pend_q, pend_d;
  logic [7:0]       hdr0_q, hdr1_q, cmd_q, len_q, etx0_q;
  logic [6:0]       pos_q, pos_d, pos_nx;
  logic [23:0]      acc_q;
  logic [31:0]      acc_d;
  logic [7:0]       rdata;
  logic [7:0]       data_byte;
  logic [8:0]       rd_off;
  logic [8:0]       adv;
  logic [SUM_W-1:0] raddr_sum, rp_sum;
  logic [PTR_W-1:0] raddr;
  logic             full;
  logic             wr_en;

  logic             strobe_q;
  logic [2:0]       status_q;
  logic [7:0]       command_q, frame_length_q;
  logic [4:0]       word_index_q;
  logic [31:0]      data_word_q;
  logic             word_valid_q, last_q;
  logic [7:0]       command_d, frame_length_d;

  // Window storage.
  fcd_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_ptr_q),
    .wdata_i(byte_in_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign full  = (count_q == CNT_W'(BUF_DEPTH));
  assign wr_en = cmd_i.push && !full;

  // Data byte position for the next read; past the frame any address will do.
  assign pos_nx = cmd_i.pos_clr ? 7'd0 : pos_q + 7'd1;

  // Read offset from the window head.
  always_comb begin
    case (cmd_i.rsel)
      RselHdr0: rd_off = 9'd0;
      RselHdr1: rd_off = 9'd1;
      RselCmd:  rd_off = 9'd2;
      RselLen:  rd_off = 9'd3;
      RselEtx0: rd_off = 9'd4 + {1'b0, rdata};
      RselEtx1: rd_off = 9'd5 + {1'b0, len_q};
      RselData: rd_off = ({1'b0, pos_nx} < len_q) ? 9'd4 + {2'b0, pos_nx} : 9'd4;
      default:  rd_off = 9'd0;
    endcase
  end

  // Ring address; the offset is below the depth whenever the read data is used.
  always_comb begin
    raddr_sum = SUM_W'(rd_ptr_q) + SUM_W'(rd_off);
    if (raddr_sum >= SUM_W'(BUF_DEPTH)) raddr_sum = raddr_sum - SUM_W'(BUF_DEPTH);
    raddr = raddr_sum[PTR_W-1:0];
  end

  // Pointer and count updates.
  always_comb begin
    adv      = cmd_i.drop_frame ? 9'(FrameOverhead) + {1'b0, len_q} : 9'd1;
    rp_sum   = SUM_W'(rd_ptr_q) + SUM_W'(adv);
    if (rp_sum >= SUM_W'(BUF_DEPTH)) rp_sum = rp_sum - SUM_W'(BUF_DEPTH);
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(BUF_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      count_d  = count_q + CNT_W'(1);
    end else if (cmd_i.drop_one || cmd_i.drop_frame) begin
      rd_ptr_d = rp_sum[PTR_W-1:0];
      count_d  = count_q - CNT_W'(adv);
    end
  end

  // Pending length of a header that waits for its bytes.
  always_comb begin
    pend_d = pend_q;
    if (cmd_i.set_pend)      pend_d = rdata;
    else if (cmd_i.clr_pend) pend_d = 8'd0;
  end

  // Data byte position.
  always_comb begin
    pos_d = pos_q;
    if (cmd_i.pos_clr || cmd_i.pos_inc) pos_d = pos_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
      pend_q   <= '0;
      pos_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      pos_q    <= pos_d;
    end
  end

  // Header, trailer and word assembly registers.
  assign data_byte = ({1'b0, pos_q} < len_q) ? rdata : 8'd0;
  assign acc_d     = {acc_q, data_byte};

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_hdr0) hdr0_q <= rdata;
    if (cmd_i.cap_hdr1) hdr1_q <= rdata;
    if (cmd_i.cap_cmd)  cmd_q  <= rdata;
    if (cmd_i.cap_len)  len_q  <= rdata;
    if (cmd_i.cap_etx0) etx0_q <= rdata;
    if (cmd_i.pos_inc)  acc_q  <= acc_d[23:0];
  end

  // Status toward the controller.
  always_comb begin
    stat_o.few       = CMP_W'(count_q) < CMP_W'(FrameOverhead) + CMP_W'(pend_q);
    stat_o.stx_bad   = ({hdr0_q, hdr1_q} != {StxByte, StxByte});
    stat_o.cmd_bad   = (rdata < CmdLow) || (rdata > CmdHigh);
    stat_o.len_long  = rdata > LenLimit;
    stat_o.len_wait  = CMP_W'(FrameOverhead) + CMP_W'(rdata) > CMP_W'(count_q);
    stat_o.etx_bad   = {etx0_q, rdata} != {EtxByte, EtxByte};
    stat_o.len_zero  = (len_q == 8'd0);
    stat_o.word_end  = (pos_q[1:0] == 2'b11);
    stat_o.frame_end = (pos_q[1:0] == 2'b11) && ({1'b0, pos_q} + 8'd1 >= len_q);
  end

  // Command and length fields of a result depend on how far the parse got.
  always_comb begin
    case (cmd_i.emit_status) inside
      StFew: begin
        command_d      = 8'd0;
        frame_length_d = pend_q;
      end
      StStx: begin
        command_d      = 8'd0;
        frame_length_d = 8'd0;
      end
      StCmd: begin
        command_d      = rdata;
        frame_length_d = 8'd0;
      end
      StLong, StWait: begin
        command_d      = cmd_q;
        frame_length_d = rdata;
      end
      default: begin
        command_d      = cmd_q;
        frame_length_d = len_q;
      end
    endcase
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q       <= cmd_i.emit_status;
      command_q      <= command_d;
      frame_length_q <= frame_length_d;
      word_index_q   <= cmd_i.emit_word ? pos_q[6:2] : 5'd0;
      data_word_q    <= cmd_i.emit_word ? acc_d : 32'd0;
      word_valid_q   <= cmd_i.emit_word;
      last_q         <= cmd_i.emit_last;
    end
  end

  assign strobe_o       = strobe_q;
  assign status_o       = status_q;
  assign command_o      = command_q;
  assign frame_length_o = frame_length_q;
  assign word_index_o   = word_index_q;
  assign data_word_o    = data_word_q;
  assign word_valid_o   = word_valid_q;
  assign last_o         = last_q;

endmodule

// File: rtl/framed_command_deframer_core.sv
// ----------------------------------------------------------------------------
// Framed command deframer core
// Receive window and frame parser for a framed serial link.
// ----------------------------------------------------------------------------
// A request is accepted on a rising edge with start high and busy low.
// With mode_i low the request pushes byte_in_i into the ring window; a byte
// that arrives while the window is full is dropped. A push gives no result, so
// busy stays low.
// With mode_i high the request makes one parse attempt at the window head.
// Results appear on the result ports for one cycle each, marked by strobe_o;
// last_o marks the final result of the attempt.
// Steps of a poll, all bound by the single registered read port of the
// window RAM, which delivers one byte per cycle: the byte count is checked
// against the frame known so far; the two STX bytes and the command byte
// are read and checked; the length is read and checked against its limit
// and the bytes held; the two ETX bytes are read and checked, and an empty
// frame ends there; the data bytes are then read in order, and a word
// result goes out after every fourth data byte. A failed check ends the
// attempt with a single result. busy stays high for the whole attempt, so
// no new request is taken until it ends.
// The receiver cannot stall; each result is taken in its strobe cycle.
// Reset clears the pointers, the byte count and the pending length; window
// contents need no clearing since only written bytes are ever parsed.
// ----------------------------------------------------------------------------
module framed_command_deframer_core #(
  parameter int BUF_DEPTH = fcd_pkg::BufDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [7:0]  byte_in_i,
  output logic        strobe_o,
  output logic [2:0]  status_o,
  output logic [7:0]  command_o,
  output logic [7:0]  frame_length_o,
  output logic [4:0]  word_index_o,
  output logic [31:0] data_word_o,
  output logic        word_valid_o,
  output logic        last_o
);
  import fcd_pkg::*;

  fcd_cmd_t  cmd;
  fcd_stat_t stat;
  logic      busy_int;

  // Sequencer.
  fcd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .mode_i (mode_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_int)
  );

  // Window and result datapath.
  fcd_dp #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_in_i     (byte_in_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .strobe_o      (strobe_o),
    .status_o      (status_o),
    .command_o     (command_o),
    .frame_length_o(frame_length_o),
    .word_index_o  (word_index_o),
    .data_word_o   (data_word_o),
    .word_valid_o  (word_valid_o),
    .last_o        (last_o)
  );

  assign busy = busy_int;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed command deframer testbench
// Feeds pushes and parse polls to the deframer core and checks every result
// strobe against a byte-exact prediction of the receive window and parser.
// ----------------------------------------------------------------------------
module testbench;
  import fcd_pkg::*;

  localparam int WindowDepth = BufDepthDefault;
  localparam int ClkPeriod   = 12;
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 140;
  localparam int MaxPrinted  = 40;
  localparam int MaxLength   = (WindowDepth - FrameOverhead > MaxWords * 4) ?
                               MaxWords * 4 : WindowDepth - FrameOverhead;

  // One parse result as the block presents it.
  typedef struct packed {
    fcd_status_e status;
    logic [7:0]  command;
    logic [7:0]  frame_length;
    logic [4:0]  word_index;
    logic [31:0] data_word;
    logic        word_valid;
    logic        last;
  } deframe_result_t;

  // Window model and store of results still to arrive.
  class deframer_scoreboard;
    logic [7:0]      window_bytes [WindowDepth];
    int unsigned     head;
    int unsigned     tail;
    int unsigned     fill;
    int unsigned     wait_len;
    deframe_result_t results_due [$];
    int unsigned     mismatches;

    function new();
      head       = 0;
      tail       = 0;
      fill       = 0;
      wait_len   = 0;
      mismatches = 0;
    endfunction

    function logic [7:0] peek(int unsigned offset);
      return window_bytes[(head + offset) % WindowDepth];
    endfunction

    function void add_result(fcd_status_e status, logic [7:0] cmd, logic [7:0] len,
                             logic [4:0] idx, logic [31:0] word, logic valid,
                             logic last);
      deframe_result_t r;
      r.status       = status;
      r.command      = cmd;
      r.frame_length = len;
      r.word_index   = idx;
      r.data_word    = word;
      r.word_valid   = valid;
      r.last         = last;
      results_due.push_back(r);
    endfunction

    function void drop_bytes(int unsigned n);
      if (n > fill) begin
        n = fill;
      end
      head = (head + n) % WindowDepth;
      fill = fill - n;
    endfunction

    // A framing error discards the head byte and any pending length.
    function void reject_head(fcd_status_e status, logic [7:0] cmd, logic [7:0] len);
      drop_bytes(1);
      wait_len = 0;
      add_result(status, cmd, len, 5'd0, 32'd0, 1'b0, 1'b1);
    endfunction

    // Applies one accepted request. For a poll the status of its first result
    // is returned; a push has no result and its return value means nothing.
    function fcd_status_e apply_request(logic mode, logic [7:0] value);
      int unsigned cmd;
      int unsigned len;
      int unsigned limit;
      int unsigned nwords;
      int unsigned w;
      int unsigned b;
      int unsigned pos;
      logic [31:0] word;
      if (!mode) begin
        if (fill < WindowDepth) begin
          window_bytes[tail] = value;
          tail = (tail + 1) % WindowDepth;
          fill++;
        end
        return StFew;
      end
      if (fill < FrameOverhead + wait_len) begin
        add_result(StFew, 8'd0, 8'(wait_len), 5'd0, 32'd0, 1'b0, 1'b1);
        return StFew;
      end
      if ({peek(0), peek(1)} != {StxByte, StxByte}) begin
        reject_head(StStx, 8'd0, 8'd0);
        return StStx;
      end
      cmd = peek(2);
      if (cmd < CmdLow || cmd > CmdHigh) begin
        reject_head(StCmd, 8'(cmd), 8'd0);
        return StCmd;
      end
      len   = peek(3);
      limit = WindowDepth - FrameOverhead;
      if (limit > MaxWords * 4) begin
        limit = MaxWords * 4;
      end
      if (len > limit) begin
        reject_head(StLong, 8'(cmd), 8'(len));
        return StLong;
      end
      // Header is sound but the tail of the frame has not arrived yet.
      if (FrameOverhead + len > fill) begin
        wait_len = len;
        add_result(StWait, 8'(cmd), 8'(len), 5'd0, 32'd0, 1'b0, 1'b1);
        return StWait;
      end
      if ({peek(4 + len), peek(5 + len)} != {EtxByte, EtxByte}) begin
        reject_head(StEtx, 8'(cmd), 8'(len));
        return StEtx;
      end
      // Good frame: pack the data big-endian, zero-filling a short last word.
      if (len == 0) begin
        add_result(StWord, 8'(cmd), 8'd0, 5'd0, 32'd0, 1'b0, 1'b1);
      end else begin
        nwords = (len + 3) / 4;
        for (w = 0; w < nwords; w++) begin
          word = 32'd0;
          for (b = 0; b < 4; b++) begin
            pos = w * 4 + b;
            word[31 - 8 * b -: 8] = (pos < len) ? peek(4 + pos) : 8'h00;
          end
          add_result(StWord, 8'(cmd), 8'(len), 5'(w), word, 1'b1, w + 1 == nwords);
        end
      end
      drop_bytes(FrameOverhead + len);
      wait_len = 0;
      return StWord;
    endfunction

    // Checks one strobed result against the oldest outstanding prediction.
    function void compare_result(logic [2:0] status, logic [7:0] cmd, logic [7:0] len,
                                 logic [4:0] idx, logic [31:0] word, logic valid,
                                 logic last);
      deframe_result_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxPrinted) begin
          $display("%0t: unexpected result, expected none, actual status %0d cmd %02h",
                   $time, status, cmd);
        end
        return;
      end
      want = results_due.pop_front();
      if (status !== want.status || cmd !== want.command || len !== want.frame_length ||
          idx !== want.word_index || word !== want.data_word ||
          valid !== want.word_valid || last !== want.last) begin
        mismatches++;
        if (mismatches <= MaxPrinted) begin
          $display("%0t: result mismatch", $time);
          $display("  expected status %0d cmd %02h len %0d idx %0d data %08h valid %b last %b",
                   want.status, want.command, want.frame_length, want.word_index,
                   want.data_word, want.word_valid, want.last);
          $display("  actual   status %0d cmd %02h len %0d idx %0d data %08h valid %b last %b",
                   status, cmd, len, idx, word, valid, last);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        start     = 1'b0;
  logic        mode_i    = 1'b0;
  logic [7:0]  byte_in_i = 8'h00;
  logic        busy;
  logic        strobe_o;
  logic [2:0]  status_o;
  logic [7:0]  command_o;
  logic [7:0]  frame_length_o;
  logic [4:0]  word_index_o;
  logic [31:0] data_word_o;
  logic        word_valid_o;
  logic        last_o;

  deframer_scoreboard sb;
  bit                 idle_enable;
  int unsigned        cycle_count;

  framed_command_deframer_core #(
    .BUF_DEPTH(WindowDepth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .byte_in_i     (byte_in_i),
    .strobe_o      (strobe_o),
    .status_o      (status_o),
    .command_o     (command_o),
    .frame_length_o(frame_length_o),
    .word_index_o  (word_index_o),
    .data_word_o   (data_word_o),
    .word_valid_o  (word_valid_o),
    .last_o        (last_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  initial begin
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) begin
      @(posedge clk_i);
    end
    $display("framed_command_deframer_core verification failed");
    $finish;
  end

  // Every result is taken in its strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      sb.compare_result(status_o, command_o, frame_length_o, word_index_o, data_word_o,
                        word_valid_o, last_o);
    end
  end

  // Presents one request, with an optional random gap, and waits for acceptance.
  task automatic issue(input logic mode, input logic [7:0] value,
                       output fcd_status_e first_status);
    if (idle_enable && $urandom_range(99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start     <= 1'b1;
    mode_i    <= mode;
    byte_in_i <= value;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    first_status = sb.apply_request(mode, value);
  endtask

  // Pushes one byte.
  task automatic push_byte(input logic [7:0] value);
    fcd_status_e s;
    issue(1'b0, value, s);
  endtask

  // Polls until the parser reports that it needs more bytes, or 300 polls have gone.
  task automatic parse_window();
    fcd_status_e s;
    int          n;
    n = 0;
    forever begin
      issue(1'b1, 8'($urandom_range(255)), s);
      n++;
      if (s == StFew || s == StWait || n >= 300) break;
    end
  endtask

  // Pushes a frame built from the given fields; data_fill below zero means
  // random data. Parsing runs once split_at bytes have gone in.
  task automatic send_frame(input logic [15:0] stx, input logic [7:0] cmd,
                            input logic [7:0] len_byte, input int ndata,
                            input logic [15:0] etx, input int split_at,
                            input int data_fill);
    logic [7:0] bytes [$];
    bytes.push_back(stx[15:8]);
    bytes.push_back(stx[7:0]);
    bytes.push_back(cmd);
    bytes.push_back(len_byte);
    for (int i = 0; i < ndata; i++) begin
      bytes.push_back((data_fill < 0) ? 8'($urandom_range(255)) : 8'(data_fill));
    end
    bytes.push_back(etx[15:8]);
    bytes.push_back(etx[7:0]);
    for (int i = 0; i < bytes.size(); i++) begin
      if (i == split_at) begin
        parse_window();
      end
      push_byte(bytes[i]);
    end
  endtask

  localparam logic [15:0] GoodStx = {StxByte, StxByte};
  localparam logic [15:0] GoodEtx = {EtxByte, EtxByte};

  initial begin
    fcd_status_e s;

    sb          = new();
    idle_enable = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A poll on the empty window.
    issue(1'b1, 8'hFF, s);

    // The largest frame fills the window exactly; two more bytes are dropped.
    // This stretch runs back to back with no idling.
    idle_enable = 1'b0;
    send_frame(GoodStx, CmdHigh, 8'(MaxLength), MaxLength, GoodEtx, -1, -1);
    push_byte(8'($urandom_range(255)));
    push_byte(8'($urandom_range(255)));
    idle_enable = 1'b1;
    parse_window();

    // A frame that arrives in pieces: awaiting length, then too few bytes.
    push_byte(StxByte);
    push_byte(StxByte);
    push_byte(8'h03);
    push_byte(8'd10);
    for (int i = 0; i < 2; i++) begin
      push_byte(8'($urandom_range(255)));
    end
    issue(1'b1, 8'h00, s);
    for (int i = 0; i < 4; i++) begin
      push_byte(8'($urandom_range(255)));
    end
    issue(1'b1, 8'h00, s);
    for (int i = 0; i < 4; i++) begin
      push_byte(8'($urandom_range(255)));
    end
    push_byte(EtxByte);
    push_byte(EtxByte);
    parse_window();

    // Each framing error and the command and length bounds.
    send_frame(GoodStx, 8'h00, 8'h00, 0, GoodEtx, -1, -1);
    parse_window();
    send_frame(GoodStx, 8'h09, 8'h01, 1, GoodEtx, -1, -1);
    parse_window();
    send_frame(16'hFFFE, CmdLow, 8'h00, 0, GoodEtx, -1, -1);
    parse_window();
    send_frame(GoodStx, CmdHigh, 8'(MaxLength + 1), 0, GoodEtx, -1, -1);
    parse_window();
    send_frame(GoodStx, 8'h02, 8'h01, 1, 16'hFEFF, -1, -1);
    parse_window();
    start <= 1'b0;

    // Let the last results drain, then give the block time to settle.
    while (sb.results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("framed_command_deframer_core verification clean");
    end else begin
      $display("framed_command_deframer_core verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/fcd_pkg.sv
rtl/fcd_ram.sv
rtl/fcd_ctrl.sv
rtl/fcd_dp.sv
rtl/framed_command_deframer_core.sv
verif/testbench.sv
